// ----- hdl/mtep_pkg.sv -----
// Shared types, codes and constants of the MIDI track event parser.
package mtep_pkg;

	// Parameter defaults
	localparam int TIME_WIDTH_DEF = 32;
	localparam int FIFO_DEPTH_DEF = 4;

	// Field widths
	localparam int VLQ_W = 28;

	// Byte codes
	localparam logic [7:0] DATA_MASK   = 8'h7f;
	localparam logic [7:0] STATUS_BIT  = 8'h80;
	localparam logic [7:0] SYSEX_START = 8'hf0;
	localparam logic [7:0] SYSEX_ESC   = 8'hf7;
	localparam logic [7:0] META_STATUS = 8'hff;
	localparam logic [3:0] PROG_HI     = 4'hc;
	localparam logic [3:0] CHPRESS_HI  = 4'hd;

	// Register reset values and paddr[2] register selects
	localparam logic [9:0] MAX_PAYLOAD_RST = 10'd370;
	localparam logic [1:0] TIME_SHIFT_RST  = 2'd1;
	localparam logic       REG_MAX_PAYLOAD = 1'b0;
	localparam logic       REG_TIME_SHIFT  = 1'b1;

	// Result kinds
	localparam logic [2:0] KIND_CHANNEL  = 3'd0;
	localparam logic [2:0] KIND_META     = 3'd1;
	localparam logic [2:0] KIND_SYSEX    = 3'd2;
	localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
	localparam logic [2:0] KIND_OVERSIZE = 3'd4;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd5;
	localparam logic [2:0] KIND_NO_RS    = 3'd6;

	// Parser phase, one-hot
	typedef enum logic [6:0] {
		PH_DELTA   = 7'b0000001,
		PH_STATUS  = 7'b0000010,
		PH_DATA1   = 7'b0000100,
		PH_DATA2   = 7'b0001000,
		PH_MTYPE   = 7'b0010000,
		PH_LEN     = 7'b0100000,
		PH_PAYLOAD = 7'b1000000
	} phase_t;

	// Event record passed from parser to output stage
	typedef struct packed {
		logic [2:0]       kind;
		logic [31:0]      event_time;
		logic [7:0]       status_byte;
		logic [7:0]       first_data;
		logic [7:0]       second_data;
		logic [VLQ_W-1:0] length;
		logic             last;
	} rec_t;

	// Configuration seen by the parser
	typedef struct packed {
		logic [9:0] max_payload;
		logic [1:0] time_shift;
	} cfg_t;

	// Program change and channel pressure carry one data byte
	function automatic logic two_byte_status(input logic [7:0] st);
		return (st[7:4] == PROG_HI) || (st[7:4] == CHPRESS_HI);
	endfunction

endpackage

// ----- hdl/midi_track_event_parser.sv -----
// An event is queued as its last byte is taken, then moves to the free result register.
// Throughput: one track byte per cycle while the event queue is not full.
// A four-entry event queue lets the parser keep taking bytes while a result waits.
// Reset (arst_n low) clears parser phase, time, running status, the queue and the
// output valid; max_payload returns to 370 and time_shift to 1.
module midi_track_event_parser #(
	parameter int TIME_WIDTH = mtep_pkg::TIME_WIDTH_DEF,
	parameter int FIFO_DEPTH = mtep_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  track_byte,
	input  logic        track_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] event_time,
	output logic [7:0]  status_byte,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic [9:0]  msg_length,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mtep_pkg::*;

	cfg_t cfg_q;
	rec_t front_rec, q_rec;
	logic front_valid, q_full, q_valid, q_pop, cfg_wr;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload <= MAX_PAYLOAD_RST;
			cfg_q.time_shift  <= TIME_SHIFT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAX_PAYLOAD)
				cfg_q.max_payload <= pwdata[9:0];
			else
				cfg_q.time_shift <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TIME_SHIFT) ? 32'(cfg_q.time_shift)
	                                             : 32'(cfg_q.max_payload);

	assign in_ready = !q_full;

	mtep_front #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.track_byte (track_byte),
		.track_start(track_start),
		.cfg        (cfg_q),
		.rec_valid  (front_valid),
		.rec        (front_rec)
	);

	mtep_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_valid),
		.wr_data  (front_rec),
		.full     (q_full),
		.rd_en    (q_pop),
		.not_empty(q_valid),
		.rd_data  (q_rec)
	);

	mtep_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_rec      (q_rec),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.event_time (event_time),
		.status_byte(status_byte),
		.first_data (first_data),
		.second_data(second_data),
		.msg_length (msg_length),
		.last       (last)
	);

endmodule

// ----- hdl/mtep_front.sv -----
// Parser front end: delta time decode, running status and event classification.
module mtep_front #(
	parameter int TIME_WIDTH = mtep_pkg::TIME_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  logic [7:0]    track_byte,
	input  logic          track_start,
	input  mtep_pkg::cfg_t cfg,
	output logic          rec_valid,
	output mtep_pkg::rec_t rec
);
	import mtep_pkg::*;

	phase_t                phase_q, phase_d, cur_phase;
	logic [VLQ_W-1:0]      vlq_q, vlq_d, cur_vlq, vlq_shift;
	logic [7:0]            run_q, run_d;
	logic [7:0]            stat_q, stat_d;
	logic [7:0]            held_q, held_d;
	logic [TIME_WIDTH-1:0] time_q, time_d, cur_time;
	logic [VLQ_W-1:0]      left_q, left_d, left_dec;
	logic                  skip_q, skip_d;
	logic [30:0]           delta_scaled;
	logic                  in_fire, emit, over;

	assign in_fire = in_valid && in_ready;

	// Track start wipes the control state ahead of this byte
	assign cur_phase    = track_start ? PH_DELTA : phase_q;
	assign cur_vlq      = track_start ? '0 : vlq_q;
	assign cur_time     = track_start ? '0 : time_q;
	assign vlq_shift    = {cur_vlq[VLQ_W-8:0], track_byte[6:0] & DATA_MASK[6:0]};
	assign delta_scaled = 31'(vlq_shift) << cfg.time_shift;
	assign left_dec     = left_q - VLQ_W'(1);
	assign over         = vlq_shift > VLQ_W'(cfg.max_payload);

	// Phase decode and record build
	always_comb begin
		phase_d = PH_DELTA;
		vlq_d   = cur_vlq;
		run_d   = track_start ? '0 : run_q;
		stat_d  = stat_q;
		held_d  = held_q;
		time_d  = cur_time;
		left_d  = left_q;
		skip_d  = skip_q;
		emit    = 1'b0;
		rec             = '0;
		rec.event_time  = 32'(time_q);
		rec.status_byte = stat_q;
		case (cur_phase)
			PH_STATUS: begin
				if (!track_byte[7]) begin
					if (run_q == '0) begin
						emit            = 1'b1;
						rec.kind        = KIND_NO_RS;
						rec.status_byte = '0;
						rec.first_data  = track_byte;
					end else begin
						stat_d = run_q;
						if (two_byte_status(run_q)) begin
							emit            = 1'b1;
							rec.kind        = KIND_CHANNEL;
							rec.status_byte = run_q;
							rec.first_data  = track_byte;
							rec.length      = VLQ_W'(2);
						end else begin
							held_d  = track_byte;
							phase_d = PH_DATA2;
						end
					end
				end else if (track_byte < SYSEX_START) begin
					run_d   = track_byte;
					stat_d  = track_byte;
					phase_d = PH_DATA1;
				end else if (track_byte == META_STATUS) begin
					stat_d  = track_byte;
					phase_d = PH_MTYPE;
				end else if (track_byte == SYSEX_START || track_byte == SYSEX_ESC) begin
					stat_d  = track_byte;
					held_d  = '0;
					vlq_d   = '0;
					phase_d = PH_LEN;
				end else begin
					// unknown status: resync on the next delta time
					emit            = 1'b1;
					rec.kind        = KIND_UNKNOWN;
					rec.status_byte = track_byte;
				end
			end
			PH_DATA1: begin
				if (two_byte_status(stat_q)) begin
					emit           = 1'b1;
					rec.kind       = KIND_CHANNEL;
					rec.first_data = track_byte;
					rec.length     = VLQ_W'(2);
				end else begin
					held_d  = track_byte;
					phase_d = PH_DATA2;
				end
			end
			PH_DATA2: begin
				emit            = 1'b1;
				rec.kind        = KIND_CHANNEL;
				rec.first_data  = held_q;
				rec.second_data = track_byte;
				rec.length      = VLQ_W'(3);
			end
			PH_MTYPE: begin
				held_d  = track_byte;
				vlq_d   = '0;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				vlq_d = vlq_shift;
				if (track_byte[7]) begin
					phase_d = PH_LEN;
				end else begin
					vlq_d          = '0;
					left_d         = vlq_shift;
					skip_d         = over;
					phase_d        = (vlq_shift == '0) ? PH_DELTA : PH_PAYLOAD;
					emit           = 1'b1;
					rec.first_data = held_q;
					rec.length     = vlq_shift;
					if (over)
						rec.kind = KIND_OVERSIZE;
					else if (stat_q == META_STATUS)
						rec.kind = KIND_META;
					else
						rec.kind = KIND_SYSEX;
				end
			end
			PH_PAYLOAD: begin
				left_d         = left_dec;
				emit           = !skip_q;
				rec.kind       = KIND_PAYLOAD;
				rec.first_data = track_byte;
				if (left_dec == '0) begin
					skip_d   = 1'b0;
					rec.last = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			default: begin
				// delta time, seven bits a byte
				vlq_d = vlq_shift;
				if (!track_byte[7]) begin
					time_d  = cur_time + TIME_WIDTH'(delta_scaled);
					vlq_d   = '0;
					phase_d = PH_STATUS;
				end
			end
		endcase
	end

	assign rec_valid = in_fire && emit;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			vlq_q   <= '0;
			run_q   <= '0;
			time_q  <= '0;
			skip_q  <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			vlq_q   <= vlq_d;
			run_q   <= run_d;
			time_q  <= time_d;
			skip_q  <= skip_d;
		end
	end

	// Event context, always written before it is read
	always_ff @(posedge clk) begin
		if (in_fire) begin
			stat_q <= stat_d;
			held_q <= held_d;
			left_q <= left_d;
		end
	end

endmodule

// ----- hdl/mtep_fifo.sv -----
// Short event queue between the parser and the output stage.
module mtep_fifo #(
	parameter int DEPTH = mtep_pkg::FIFO_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mtep_pkg::rec_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output logic           not_empty,
	output mtep_pkg::rec_t rd_data
);
	import mtep_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ----- hdl/mtep_back.sv -----
// Output stage: formats queued events and holds the result register.
module mtep_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mtep_pkg::rec_t q_rec,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     kind,
	output logic [31:0]    event_time,
	output logic [7:0]     status_byte,
	output logic [7:0]     first_data,
	output logic [7:0]     second_data,
	output logic [9:0]     msg_length,
	output logic           last
);
	import mtep_pkg::*;

	logic       valid_q;
	logic [9:0] len_sat;

	assign q_pop     = q_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;

	// Length saturates at the field's top
	assign len_sat = (q_rec.length > VLQ_W'(10'h3ff)) ? 10'h3ff : q_rec.length[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	// Result beat register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind        <= q_rec.kind;
			event_time  <= q_rec.event_time;
			status_byte <= q_rec.status_byte;
			first_data  <= q_rec.first_data;
			second_data <= q_rec.second_data;
			msg_length  <= len_sat;
			last        <= q_rec.last;
		end
	end

endmodule

// ----- hdl/mtep_checker.sv -----
// Port-level checks of the MIDI track event parser, bound to the top level.
module mtep_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [31:0] event_time,
	input logic [9:0]  msg_length,
	input logic        last
);
	import mtep_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(event_time))
		else $error("result beat changed while stalled");

	// Only payload bytes close an event
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == KIND_PAYLOAD)
		else $error("last flag on a non-payload result");

	// Channel messages are two or three bytes
	a_chan_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CHANNEL |-> msg_length == 10'd2 || msg_length == 10'd3)
		else $error("bad channel message length");

	// Kind never takes the unused code
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind != 3'd7)
		else $error("kind code out of range");

	// Payload bytes and status-only results carry no length
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_PAYLOAD || kind == KIND_UNKNOWN) |-> msg_length == 10'd0)
		else $error("length on a payload or unknown-status result");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.event_time(event_time),
	.msg_length(msg_length),
	.last      (last)
);
